### rtl/mrq_pkg.sv
// shared types, codes and defaults for the match-remove queue
package mrq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 64;

    localparam int OP_W     = 2;
    localparam int TAG_W    = 64;
    localparam int SIZE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [TAG_W-1:0]  party_tag;
        logic [SIZE_W-1:0] party_size;
    } mrq_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                listed;
        logic [TAG_W-1:0]    entry_tag;
        logic [SIZE_W-1:0]   entry_size;
        logic [COUNT_W-1:0]  entry_count;
        logic                last;
    } mrq_out_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic capture;
        logic remove;
        logic rotate;
    } mrq_ctrl_t;

endpackage

### rtl/match_remove_queue_unit.sv
// top level of the match-remove queue: cell chain, sequencer and result register
//
// An ordered queue of up to QUEUE_DEPTH entries (tag and group size), held in a
// row of cells with the oldest entry in cell 0. Insert appends at the first empty
// cell. Remove: in the accept cycle every cell registers whether its size equals
// the request; once the output register is free, a priority chain picks the
// oldest hit and that cell and every cell behind it pull their younger neighbor
// forward. After its accept cycle, List shows one held entry per result while the
// output register is free: the cells rotate once per result and the head cell is
// shown, so after the last result the order is back as it was. Insert, full, empty
// and unused operations finish in the accept cycle. Results sit in an output
// register, so a stalled result costs no state; one request is worked on at a time
// and the next is taken once the current one has placed its final result.
module match_remove_queue_unit #(
    parameter int QUEUE_DEPTH = mrq_pkg::DEPTH_DEF,
    parameter int TAG_BITS    = mrq_pkg::TAG_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mrq_pkg::mrq_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output mrq_pkg::mrq_out_t rsp
);
    import mrq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REMOVE = 2'd1;
    localparam logic [1:0] S_LIST   = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             rsp_valid_reg, rsp_valid_next;
    mrq_out_t         rsp_reg, rsp_next;

    mrq_ctrl_t        ctrl;
    logic             req_take;
    logic             out_free;

    // cell chain wiring
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [TAG_BITS-1:0]    cell_tag  [QUEUE_DEPTH];
    logic [SIZE_W-1:0]      cell_size [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]   hit_chain;
    logic [QUEUE_DEPTH-1:0] cell_take;
    logic [TAG_BITS-1:0]    new_tag;
    logic [TAG_BITS-1:0]    got_tag;
    logic [SIZE_W-1:0]      got_size;

    assign new_tag      = req.party_tag[TAG_BITS-1:0];
    assign hit_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic                prev_v;
            logic                next_v;
            logic [TAG_BITS-1:0] next_t;
            logic [SIZE_W-1:0]   next_s;

            if (gi == 0)
            begin : g_head
                assign prev_v = 1'b1;
            end
            else
            begin : g_body
                assign prev_v = cell_valid[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_v = 1'b0;
                assign next_t = '0;
                assign next_s = '0;
            end
            else
            begin : g_mid
                assign next_v = cell_valid[gi+1];
                assign next_t = cell_tag[gi+1];
                assign next_s = cell_size[gi+1];
            end

            mrq_cell #(
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_tag    (new_tag),
                .new_size   (req.party_size),
                .find_size  (req.party_size),
                .prev_valid (prev_v),
                .next_valid (next_v),
                .next_tag   (next_t),
                .next_size  (next_s),
                .head_tag   (cell_tag[0]),
                .head_size  (cell_size[0]),
                .hit_in     (hit_chain[gi]),
                .valid      (cell_valid[gi]),
                .tag        (cell_tag[gi]),
                .size       (cell_size[gi]),
                .hit_out    (hit_chain[gi+1]),
                .take       (cell_take[gi])
            );
        end
    endgenerate

    // at most one cell takes, so an or over the cells picks the removed entry
    always_comb
    begin
        got_tag  = '0;
        got_size = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (cell_take[i])
            begin
                got_tag  = got_tag | cell_tag[i];
                got_size = got_size | cell_size[i];
            end
        end
    end

    // a new result may be loaded when the register is empty or drains this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) && out_free);
    assign req_take  = req_valid && !req_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ctrl           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    rsp_next.listed      = 1'b0;
                    rsp_next.entry_tag   = '0;
                    rsp_next.entry_size  = '0;
                    rsp_next.entry_count = COUNT_W'(count_reg);
                    rsp_next.last        = 1'b1;
                    case (req.operation)
                        OP_INSERT:
                        begin
                            rsp_valid_next = 1'b1;
                            if (count_reg == CNT_FULL)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                ctrl.insert          = 1'b1;
                                count_next           = count_reg + CNT_ONE;
                                rsp_next.status      = ST_INSERTED;
                                rsp_next.entry_count = COUNT_W'(count_reg + CNT_ONE);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next  = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.capture = 1'b1;
                                state_next   = S_REMOVE;
                            end
                        end
                        OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next  = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                left_next  = count_reg;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            // unused code: transfer taken, no result
                        end
                    endcase
                end
            end
            S_REMOVE:
            begin
                if (out_free)
                begin
                    ctrl.remove    = 1'b1;
                    rsp_valid_next = 1'b1;
                    rsp_next.listed = 1'b0;
                    rsp_next.last   = 1'b1;
                    if (hit_chain[QUEUE_DEPTH])
                    begin
                        count_next           = count_reg - CNT_ONE;
                        rsp_next.status      = ST_REMOVED;
                        rsp_next.entry_tag   = TAG_W'(got_tag);
                        rsp_next.entry_size  = got_size;
                        rsp_next.entry_count = COUNT_W'(count_reg - CNT_ONE);
                    end
                    else
                    begin
                        rsp_next.status      = ST_NOT_FOUND;
                        rsp_next.entry_tag   = '0;
                        rsp_next.entry_size  = '0;
                        rsp_next.entry_count = COUNT_W'(count_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    ctrl.rotate          = 1'b1;
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = ST_LISTED;
                    rsp_next.listed      = 1'b1;
                    rsp_next.entry_tag   = TAG_W'(cell_tag[0]);
                    rsp_next.entry_size  = cell_size[0];
                    rsp_next.entry_count = COUNT_W'(count_reg);
                    rsp_next.last        = (left_reg == CNT_ONE);
                    left_next            = left_reg - CNT_ONE;
                    if (left_reg == CNT_ONE)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result payload, held while stalled
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/mrq_cell.sv
// one queue slot: holds an entry, compares its size and trades data with its neighbors
module mrq_cell #(
    parameter int TAG_BITS = mrq_pkg::TAG_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mrq_pkg::mrq_ctrl_t        ctrl,
    input  logic [TAG_BITS-1:0]       new_tag,
    input  logic [mrq_pkg::SIZE_W-1:0] new_size,
    input  logic [mrq_pkg::SIZE_W-1:0] find_size,
    input  logic                      prev_valid,
    input  logic                      next_valid,
    input  logic [TAG_BITS-1:0]       next_tag,
    input  logic [mrq_pkg::SIZE_W-1:0] next_size,
    input  logic [TAG_BITS-1:0]       head_tag,
    input  logic [mrq_pkg::SIZE_W-1:0] head_size,
    input  logic                      hit_in,
    output logic                      valid,
    output logic [TAG_BITS-1:0]       tag,
    output logic [mrq_pkg::SIZE_W-1:0] size,
    output logic                      hit_out,
    output logic                      take
);
    import mrq_pkg::*;

    logic                valid_reg, valid_next;
    logic                match_reg, match_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic                fill;

    assign fill    = ctrl.insert && !valid_reg && prev_valid;
    assign hit_out = hit_in || match_reg;
    assign take    = match_reg && !hit_in;

    always_comb
    begin
        valid_next = valid_reg;
        match_next = match_reg;
        tag_next   = tag_reg;
        size_next  = size_reg;
        if (fill)
        begin
            valid_next = 1'b1;
            tag_next   = new_tag;
            size_next  = new_size;
        end
        if (ctrl.capture)
        begin
            match_next = valid_reg && (size_reg == find_size);
        end
        // close the gap: every slot at or behind the hit pulls from its younger neighbor
        if (ctrl.remove && hit_out)
        begin
            valid_next = next_valid;
            tag_next   = next_tag;
            size_next  = next_size;
            match_next = 1'b0;
        end
        // rotate held entries; the youngest slot takes the head
        if (ctrl.rotate && valid_reg)
        begin
            tag_next  = next_valid ? next_tag : head_tag;
            size_next = next_valid ? next_size : head_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        size_reg <= size_next;
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;
    assign size  = size_reg;

endmodule
